// ===== rtl/bsn_pkg.sv =====
package bsn_pkg;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_en;
    logic sort_en;
    logic flip;
    logic emit_en;
  } cmd_t;

  typedef struct packed {
    logic load_done;
    logic emit_done;
  } sts_t;

  localparam int InWidth  = 16;
  localparam int OutWidth = 16;

endpackage

// ===== rtl/bsn_ctrl.sv =====
module bsn_ctrl
  import bsn_pkg::*;
#(
  parameter int MAX_ITEMS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sts_t                           sts,
  output cmd_t                           cmd,
  output logic [$clog2(MAX_ITEMS)-1:0]   stage_sel
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int LW = $clog2(IW + 1);

  state_t          state_r, state_nxt;
  logic [LW-1:0]   k_r, k_nxt;
  logic [LW-1:0]   d_r, d_nxt;
  logic            flip_r, flip_nxt;
  logic            next_size;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      k_r     <= '0;
      d_r     <= '0;
      flip_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      d_r     <= d_nxt;
      flip_r  <= flip_nxt;
    end
  end

  // stage sequence per merge size 2^k: flip, then half-cleaners at distance 2^(k-2) .. 1
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    d_nxt     = d_r;
    flip_nxt  = flip_r;
    next_size = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (sts.load_done) begin
          state_nxt = ST_SORT;
          k_nxt     = LW'(1);
          flip_nxt  = 1'b1;
        end
      end
      ST_SORT: begin
        if (flip_r) begin
          if (k_r == LW'(1)) begin
            next_size = 1'b1;
          end else begin
            flip_nxt = 1'b0;
            d_nxt    = k_r - LW'(2);
          end
        end else if (d_r == '0) begin
          next_size = 1'b1;
        end else begin
          d_nxt = d_r - LW'(1);
        end
        if (next_size) begin
          if (k_r == LW'(IW)) begin
            state_nxt = ST_EMIT;
          end else begin
            k_nxt    = k_r + LW'(1);
            flip_nxt = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (sts.emit_done) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    stage_sel = '0;
    case (state_r)
      ST_LOAD: begin
        cmd.load_en = 1'b1;
      end
      ST_SORT: begin
        cmd.sort_en = 1'b1;
        cmd.flip    = flip_r;
        stage_sel   = flip_r ? (IW'(1) << (k_r - LW'(1))) : (IW'(1) << d_r);
      end
      ST_EMIT: begin
        cmd.emit_en = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/bsn_datapath.sv =====
module bsn_datapath
  import bsn_pkg::*;
#(
  parameter int MAX_ITEMS   = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cmd_t                           cmd,
  input  logic [$clog2(MAX_ITEMS)-1:0]   stage_sel,
  output sts_t                           sts,
  input  logic                           in_valid,
  input  logic [InWidth-1:0]             in_value,
  input  logic                           in_final_item,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [OutWidth-1:0]            out_sorted_value,
  output logic                           out_final_result
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int P  = 1 << IW;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [VALUE_WIDTH-1:0] store_r  [P];
  logic [VALUE_WIDTH-1:0] sort_nxt [P];
  logic [CW-1:0]          count_r;
  logic [IW-1:0]          rd_r;
  logic                   out_valid_r;
  logic [OutWidth-1:0]    out_value_r;
  logic                   out_final_r;

  logic                   load_fire;
  logic                   load_last;
  logic                   emit_fire;
  logic                   emit_last;
  logic [VALUE_WIDTH-1:0] in_ext;

  assign in_ext    = VALUE_WIDTH'(in_value);
  assign load_fire = cmd.load_en && in_valid;
  assign load_last = in_final_item || (count_r == CW'(MAX_ITEMS - 1));
  assign emit_fire = cmd.emit_en && (!out_valid_r || !out_stall);
  assign emit_last = (CW'(rd_r) + CW'(1)) == count_r;

  assign sts.load_done = load_fire && load_last;
  assign sts.emit_done = emit_fire && emit_last;

  // one compare-exchange cell per entry; partner is j ^ (2^(l+1)-1) on flip, j ^ 2^l otherwise
  for (genvar j = 0; j < P; j++) begin : g_cell
    logic [VALUE_WIDTH-1:0] pv;
    logic [IW-1:0]          pi;
    logic                   take;

    always_comb begin
      pv = '0;
      pi = '0;
      for (int l = 0; l < IW; l++) begin
        if (stage_sel[l]) begin
          if (cmd.flip) begin
            pv = pv | store_r[IW'(j ^ ((2 << l) - 1))];
            pi = pi | IW'(j ^ ((2 << l) - 1));
          end else begin
            pv = pv | store_r[IW'(j ^ (1 << l))];
            pi = pi | IW'(j ^ (1 << l));
          end
        end
      end
      if (pi > IW'(j)) begin
        take = (CW'(pi) < count_r) && (store_r[j] > pv);
      end else begin
        take = (CW'(j) < count_r) && (pv > store_r[j]);
      end
    end

    assign sort_nxt[j] = take ? pv : store_r[j];
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      store_r[count_r[IW-1:0]] <= in_ext;
    end else if (cmd.sort_en) begin
      store_r <= sort_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_fire) begin
        count_r <= count_r + CW'(1);
        rd_r    <= '0;
      end else if (sts.emit_done) begin
        count_r <= '0;
      end
      if (emit_fire) begin
        rd_r        <= rd_r + IW'(1);
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_value_r <= OutWidth'(store_r[rd_r]);
      out_final_r <= emit_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_final_result = out_final_r;

endmodule

// ===== rtl/bitonic_sort_network.sv =====
// channel   dir  transaction                              handshake
// in_       in   in_value[15:0], in_final_item            in_valid / in_stall
// out_      out  out_sorted_value[15:0], out_final_result out_valid / out_stall
//
// A set of n values loads at one transaction per cycle. The sort then applies
// one network stage per cycle, and the n results leave at one per cycle through
// the output register while out_stall is low. The next set loads once the last
// result has entered the output register. Reset is synchronous and needs no
// clearing pass.
module bitonic_sort_network
  import bsn_pkg::*;
#(
  parameter int MAX_ITEMS   = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [InWidth-1:0]  in_value,
  input  logic                in_final_item,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OutWidth-1:0] out_sorted_value,
  output logic                out_final_result
);

  localparam int IW = $clog2(MAX_ITEMS);

  cmd_t          cmd;
  sts_t          sts;
  logic [IW-1:0] stage_sel;

  bsn_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .sts       (sts),
    .cmd       (cmd),
    .stage_sel (stage_sel)
  );

  bsn_datapath #(
    .MAX_ITEMS   (MAX_ITEMS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stage_sel        (stage_sel),
    .sts              (sts),
    .in_valid         (in_valid),
    .in_value         (in_value),
    .in_final_item    (in_final_item),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_final_result (out_final_result)
  );

  assign in_stall = !cmd.load_en;

  a_load_then_sort : assert property (@(posedge clk) disable iff (!rst_n)
    sts.load_done |=> cmd.sort_en)
    else $error("sort did not start after last load");

  a_emit_then_load : assert property (@(posedge clk) disable iff (!rst_n)
    sts.emit_done |=> cmd.load_en)
    else $error("load not reopened after last result");

  a_stage_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sort_en |-> $onehot(stage_sel))
    else $error("stage select not one-hot");

  a_no_load_in_sort : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sort_en || cmd.emit_en) |-> in_stall)
    else $error("input open while sorting or emitting");

endmodule
